@@ rtl/cpre_pkg.sv @@
// Package for the cell pixel run-length encoder.
// Holds the fixed field widths and byte codes; depends on nothing.
package cpre_pkg;

  localparam int PATTERN_W      = 8;
  localparam int IN_COLOR_W     = 4;
  localparam int MAX_COLOR_BITS = 6;
  localparam int BYTE_W         = 8;
  localparam int RUN_LEN_W      = 6;

  localparam logic [BYTE_W-1:0] HDR_BASE = 8'd192;

endpackage

@@ rtl/cpre_if.sv @@
// Channel interfaces for the cell pixel run-length encoder.
// Valid/ready handshake with payload; depends on cpre_pkg.
interface cpre_in_if;
  logic                                valid;
  logic                                ready;
  logic [cpre_pkg::PATTERN_W-1:0]      pattern_byte;
  logic [cpre_pkg::IN_COLOR_W-1:0]     fg_color;
  logic [cpre_pkg::IN_COLOR_W-1:0]     bg_color;
  logic                                end_of_line;

  modport source (output valid, output pattern_byte, output fg_color, output bg_color,
                  output end_of_line, input ready);
  modport sink   (input valid, input pattern_byte, input fg_color, input bg_color,
                  input end_of_line, output ready);
endinterface

interface cpre_out_if;
  logic                            valid;
  logic                            ready;
  logic [cpre_pkg::BYTE_W-1:0]     out_byte;
  logic                            last_of_item;

  modport source (output valid, output out_byte, output last_of_item, input ready);
  modport sink   (input valid, input out_byte, input last_of_item, output ready);
endinterface

@@ rtl/cell_pixel_rle_encoder.sv @@
// Cell pixel run-length encoder: one cell row in, PCX-style run bytes out.
// One pixel step per cycle unless a byte is due while the output stalls; a cell
// takes a step per pixel, an end-of-line step if it ends a line, an extra step for
// each step that sends two bytes and a further step when its final byte must follow
// another; output one byte/cycle while ready. A row passes the queue and the pixel
// registers; each byte waits until the next byte or the end of its cell is known.
// Reset (synchronous, active low) empties the queue and closes any open run.
module cell_pixel_rle_encoder #(
  parameter int MAX_RUN         = 63,
  parameter int PIXELS_PER_CELL = 8,
  parameter int COLOR_BITS      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  cpre_in_if.sink     in_s,
  cpre_out_if.source  out_m
);
  import cpre_pkg::*;

  localparam int QW = PIXELS_PER_CELL * COLOR_BITS + 1;

  logic                                       f_push;
  logic [PIXELS_PER_CELL-1:0][COLOR_BITS-1:0] f_pixels;
  logic                                       f_eol;
  logic                                       q_full;
  logic                                       q_valid;
  logic                                       q_pop;
  logic [QW-1:0]                              q_dout;
  logic [PIXELS_PER_CELL-1:0][COLOR_BITS-1:0] q_pixels;
  logic                                       q_eol;

  cpre_front #(
    .PIXELS_PER_CELL (PIXELS_PER_CELL),
    .COLOR_BITS      (COLOR_BITS)
  ) u_front (
    .in_s     (in_s),
    .q_full   (q_full),
    .q_push   (f_push),
    .q_pixels (f_pixels),
    .q_eol    (f_eol)
  );

  cpre_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   ({f_eol, f_pixels}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  assign q_eol    = q_dout[QW-1];
  assign q_pixels = q_dout[QW-2:0];

  cpre_back #(
    .MAX_RUN         (MAX_RUN),
    .PIXELS_PER_CELL (PIXELS_PER_CELL),
    .COLOR_BITS      (COLOR_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pixels (q_pixels),
    .q_eol    (q_eol),
    .q_pop    (q_pop),
    .out_m    (out_m)
  );

endmodule

@@ rtl/cpre_front.sv @@
// Front end: accepts a cell row and expands its pattern into pixel colors.
// Depends on cpre_pkg and cpre_in_if; feeds cpre_queue.
module cpre_front #(
  parameter int PIXELS_PER_CELL = 8,
  parameter int COLOR_BITS      = 4
) (
  cpre_in_if.sink                                  in_s,
  input  logic                                     q_full,
  output logic                                     q_push,
  output logic [PIXELS_PER_CELL-1:0][COLOR_BITS-1:0] q_pixels,
  output logic                                     q_eol
);
  import cpre_pkg::*;

  logic [MAX_COLOR_BITS-1:0]  fg_ext;
  logic [MAX_COLOR_BITS-1:0]  bg_ext;
  logic [PIXELS_PER_CELL-1:0] bit_v;

  assign fg_ext     = MAX_COLOR_BITS'(in_s.fg_color);
  assign bg_ext     = MAX_COLOR_BITS'(in_s.bg_color);
  assign in_s.ready = !q_full;
  assign q_push     = in_s.valid && !q_full;
  assign q_eol      = in_s.end_of_line;

  for (genvar i = 0; i < PIXELS_PER_CELL; i++) begin : g_pix
    localparam int BP = PIXELS_PER_CELL - 1 - i;
    if (BP < PATTERN_W) begin : g_bit
      assign bit_v[i] = in_s.pattern_byte[BP];
    end else begin : g_zero
      assign bit_v[i] = 1'b0;
    end
    assign q_pixels[i] = bit_v[i] ? fg_ext[COLOR_BITS-1:0] : bg_ext[COLOR_BITS-1:0];
  end

endmodule

@@ rtl/cpre_queue.sv @@
// Two-entry queue between the front end and the encoder back end.
// Generic payload width; depends on nothing.
module cpre_queue #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid
);
  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic [1:0]   count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop && valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/cpre_back.sv @@
// Back end: walks each queued cell's pixels one step a cycle unless stalled, keeps the
// open run and sends header and color bytes. Depends on cpre_pkg, cpre_out_if.
module cpre_back #(
  parameter int MAX_RUN         = 63,
  parameter int PIXELS_PER_CELL = 8,
  parameter int COLOR_BITS      = 4
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       q_valid,
  input  logic [PIXELS_PER_CELL-1:0][COLOR_BITS-1:0] q_pixels,
  input  logic                                       q_eol,
  output logic                                       q_pop,
  cpre_out_if.source                                 out_m
);
  import cpre_pkg::*;

  localparam int IW = $clog2(PIXELS_PER_CELL + 1);
  localparam int PW = (PIXELS_PER_CELL > 1) ? $clog2(PIXELS_PER_CELL) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_t;

  state_t                                     state_r, state_nxt;
  logic [PIXELS_PER_CELL-1:0][COLOR_BITS-1:0] pix_r, pix_nxt;
  logic                                       eol_r, eol_nxt;
  logic [IW-1:0]                              idx_r, idx_nxt;
  logic                                       sub_r, sub_nxt;
  logic [COLOR_BITS-1:0]                      run_color_r, run_color_nxt;
  logic                                       run_valid_r, run_valid_nxt;
  logic [RUN_LEN_W-1:0]                       run_len_r, run_len_nxt;
  logic                                       held_valid_r, held_valid_nxt;
  logic [BYTE_W-1:0]                          held_byte_r, held_byte_nxt;
  logic                                       out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]                          out_byte_r, out_byte_nxt;
  logic                                       out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  is_eol_step;
  logic                  last_step;
  logic [COLOR_BITS-1:0] cur_pix;
  logic                  match;
  logic [RUN_LEN_W-1:0]  len_inc;
  logic [1:0]            fl_n;
  logic [BYTE_W-1:0]     fl_b0;
  logic [1:0]            n_bytes;
  logic [BYTE_W-1:0]     b0;
  logic [BYTE_W-1:0]     b1;
  logic [BYTE_W-1:0]     cur_byte;
  logic                  has_byte;
  logic                  step_done;
  logic                  item_end;
  logic [COLOR_BITS-1:0] st_color;
  logic                  st_valid;
  logic [RUN_LEN_W-1:0]  st_len;

  assign out_free     = !out_valid_r || out_m.ready;
  assign out_m.valid        = out_valid_r;
  assign out_m.out_byte     = out_byte_r;
  assign out_m.last_of_item = out_last_r;

  assign is_eol_step = (idx_r == IW'(PIXELS_PER_CELL));
  assign last_step   = is_eol_step || ((idx_r == IW'(PIXELS_PER_CELL - 1)) && !eol_r);
  assign cur_pix     = is_eol_step ? '0 : pix_r[idx_r[PW-1:0]];
  assign match       = run_valid_r && (cur_pix == run_color_r);
  assign len_inc     = run_len_r + RUN_LEN_W'(1);

  // Bytes of the open run when it closes
  always_comb begin
    fl_n  = 2'd0;
    fl_b0 = BYTE_W'(run_color_r);
    if (run_valid_r && run_len_r >= RUN_LEN_W'(2)) begin
      fl_n  = 2'd2;
      fl_b0 = HDR_BASE + BYTE_W'(run_len_r);
    end else if (run_valid_r && run_len_r == RUN_LEN_W'(1)) begin
      fl_n = 2'd1;
    end
  end

  // Bytes and run update of the current step
  always_comb begin
    b1       = BYTE_W'(run_color_r);
    b0       = fl_b0;
    n_bytes  = fl_n;
    st_color = run_color_r;
    st_valid = run_valid_r;
    st_len   = run_len_r;
    if (is_eol_step) begin
      st_valid = 1'b0;
      st_len   = '0;
    end else if (match) begin
      if (len_inc >= RUN_LEN_W'(MAX_RUN)) begin
        n_bytes = 2'd2;
        b0      = HDR_BASE + BYTE_W'(MAX_RUN);
        st_len  = '0;
      end else begin
        n_bytes = 2'd0;
        st_len  = len_inc;
      end
    end else begin
      st_color = cur_pix;
      st_valid = 1'b1;
      st_len   = RUN_LEN_W'(1);
    end
  end

  assign cur_byte  = sub_r ? b1 : b0;
  assign has_byte  = (n_bytes != 2'd0);
  assign step_done = !((n_bytes == 2'd2) && !sub_r);
  assign item_end  = last_step && step_done;

  always_comb begin
    state_nxt      = state_r;
    pix_nxt        = pix_r;
    eol_nxt        = eol_r;
    idx_nxt        = idx_r;
    sub_nxt        = sub_r;
    run_color_nxt  = run_color_r;
    run_valid_nxt  = run_valid_r;
    run_len_nxt    = run_len_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    out_valid_nxt  = out_valid_r && !out_m.ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          pix_nxt   = q_pixels;
          eol_nxt   = q_eol;
          idx_nxt   = '0;
          sub_nxt   = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free || !((has_byte && (held_valid_r || item_end)) ||
                          (!has_byte && item_end && held_valid_r))) begin
          if (has_byte) begin
            if (held_valid_r) begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = held_byte_r;
              out_last_nxt  = 1'b0;
              held_byte_nxt = cur_byte;
            end else if (item_end) begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = cur_byte;
              out_last_nxt  = 1'b1;
            end else begin
              held_valid_nxt = 1'b1;
              held_byte_nxt  = cur_byte;
            end
          end else if (item_end && held_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = held_byte_r;
            out_last_nxt   = 1'b1;
            held_valid_nxt = 1'b0;
          end
          if (step_done) begin
            run_color_nxt = st_color;
            run_valid_nxt = st_valid;
            run_len_nxt   = st_len;
            sub_nxt       = 1'b0;
            if (item_end) begin
              if (has_byte && held_valid_r) begin
                state_nxt = ST_FLUSH;
              end else if (q_valid) begin
                q_pop   = 1'b1;
                pix_nxt = q_pixels;
                eol_nxt = q_eol;
                idx_nxt = '0;
              end else begin
                state_nxt = ST_IDLE;
              end
            end else begin
              idx_nxt = idx_r + IW'(1);
            end
          end else begin
            sub_nxt = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = held_byte_r;
          out_last_nxt   = 1'b1;
          held_valid_nxt = 1'b0;
          if (q_valid) begin
            q_pop     = 1'b1;
            pix_nxt   = q_pixels;
            eol_nxt   = q_eol;
            idx_nxt   = '0;
            sub_nxt   = 1'b0;
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pix_r       <= pix_nxt;
    eol_r       <= eol_nxt;
    held_byte_r <= held_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      sub_r        <= 1'b0;
      run_color_r  <= '0;
      run_valid_r  <= 1'b0;
      run_len_r    <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      sub_r        <= sub_nxt;
      run_color_r  <= run_color_nxt;
      run_valid_r  <= run_valid_nxt;
      run_len_r    <= run_len_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for cell_pixel_rle_encoder: directed cell rows, then random rows, each
// output byte checked against typed bytes or a run-length predictor. Uses cpre_pkg, cpre_if.
module testbench;
  import cpre_pkg::*;

  localparam int MAX_RUN      = 63;
  localparam int PIXELS       = 8;
  localparam int COLOR_BITS   = 4;
  localparam int DIR_N        = 24;
  localparam int RAND_ITEMS   = 86;
  localparam int PRED         = -1;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] pattern;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       eol;
    int         n_typed;
    logic [7:0] typed [8];
  } cell_stim_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } rle_byte_t;

  localparam logic [7:0] NO_BYTES [8] = '{default: 8'd0};

  logic clk;
  logic rst_n;

  cpre_in_if  in_if();
  cpre_out_if out_if();

  cell_pixel_rle_encoder #(
    .MAX_RUN        (MAX_RUN),
    .PIXELS_PER_CELL(PIXELS),
    .COLOR_BITS     (COLOR_BITS)
  ) i_dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_if),
    .out_m(out_if)
  );

  cell_stim_t dir_tab [DIR_N] = '{
    '{8'hFF, 4'd5,  4'd0,  1'b1, 2, '{8'd200, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{8'h00, 4'd3,  4'd15, 1'b1, 2, '{8'd200, 8'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{8'hAA, 4'd15, 4'd0,  1'b1, 8, '{8'd15, 8'd0, 8'd15, 8'd0, 8'd15, 8'd0, 8'd15, 8'd0}},
    '{8'h0F, 4'd0,  4'd15, 1'b1, 4, '{8'd196, 8'd15, 8'd196, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{8'h3C, 4'd9,  4'd9,  1'b0, 0, NO_BYTES},
    '{8'h81, 4'd9,  4'd2,  1'b1, PRED, NO_BYTES},
    '{8'hFF, 4'd7,  4'd0,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd0,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd0,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd0,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd0,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd0,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd0,  1'b0, 0, NO_BYTES},
    '{8'hFE, 4'd7,  4'd2,  1'b1, 3, '{8'd255, 8'd7, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{8'h7F, 4'd7,  4'd1,  1'b0, 1, '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{8'hFF, 4'd7,  4'd3,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd3,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd3,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd3,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd3,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd3,  1'b0, 0, NO_BYTES},
    '{8'hFF, 4'd7,  4'd0,  1'b1, 2, '{8'd255, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{8'h55, 4'd0,  4'd15, 1'b0, PRED, NO_BYTES},
    '{8'hC3, 4'd12, 4'd6,  1'b1, PRED, NO_BYTES}
  };

  cell_stim_t stim_q [$];
  rle_byte_t  pending_codes [$];
  rle_byte_t  cell_codes [$];

  logic [3:0] run_color;
  logic       run_open;
  logic [5:0] run_len;

  int err_cnt  = 0;
  int accepted = 0;
  bit held     = 1'b0;

  task automatic emit_code(input logic [7:0] v);
    cell_codes.push_back('{v, 1'b0});
  endtask

  task automatic close_run();
    if (run_open && run_len >= 2) emit_code(HDR_BASE + 8'(run_len));
    if (run_open && run_len >= 1) emit_code(8'(run_color));
    run_len = '0;
  endtask

  task automatic encode_cell(input cell_stim_t c);
    logic [3:0] pix;
    cell_codes.delete();
    for (int i = 0; i < PIXELS; i++) begin
      pix = c.pattern[PIXELS-1-i] ? c.fg : c.bg;
      if (run_open && pix == run_color) begin
        run_len = run_len + 6'd1;
      end else begin
        close_run();
        run_color = pix;
        run_open  = 1'b1;
        run_len   = 6'd1;
      end
      if (run_len >= MAX_RUN) begin
        emit_code(HDR_BASE + 8'(MAX_RUN));
        emit_code(8'(run_color));
        run_len = '0;
      end
    end
    if (c.eol) begin
      close_run();
      run_open = 1'b0;
    end
    if (cell_codes.size() > 0) cell_codes[$].last = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int on_len;
    int off_len;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && accepted >= HOLD_AFTER) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      on_len = $urandom_range(1, 24);
      out_if.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      off_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (off_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    rle_byte_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected byte %0d", out_if.out_byte);
        err_cnt++;
      end else begin
        want = pending_codes.pop_front();
        if (out_if.out_byte !== want.code) begin
          $error("out_byte: expected %0d, got %0d", want.code, out_if.out_byte);
          err_cnt++;
        end
        if (out_if.last_of_item !== want.last) begin
          $error("last_of_item: expected %0d, got %0d", want.last, out_if.last_of_item);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    cell_stim_t s;
    int idx;
    int burst;
    int gap;
    int len;
    logic [3:0] col;
    bit solid;

    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.pattern_byte <= '0;
    in_if.fg_color     <= '0;
    in_if.bg_color     <= '0;
    in_if.end_of_line  <= 1'b0;
    run_color = '0;
    run_open  = 1'b0;
    run_len   = '0;

    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    while (stim_q.size() < DIR_N + RAND_ITEMS) begin
      s.n_typed = PRED;
      s.typed   = NO_BYTES;
      if ($urandom_range(0, 3) == 0) begin
        col   = 4'($urandom_range(0, 15));
        len   = $urandom_range(6, 10);
        solid = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
          s.pattern = solid ? 8'hFF : 8'h00;
          s.fg      = solid ? col : 4'($urandom_range(0, 15));
          s.bg      = solid ? 4'($urandom_range(0, 15)) : col;
          s.eol     = (k == len - 1) && $urandom_range(0, 1);
          stim_q.push_back(s);
        end
      end else begin
        s.pattern = 8'($urandom_range(0, 255));
        s.fg      = 4'($urandom_range(0, 15));
        s.bg      = 4'($urandom_range(0, 15));
        s.eol     = ($urandom_range(0, 3) == 0);
        stim_q.push_back(s);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < stim_q.size()) begin
        s = stim_q[idx];
        in_if.valid        <= 1'b1;
        in_if.pattern_byte <= s.pattern;
        in_if.fg_color     <= s.fg;
        in_if.bg_color     <= s.bg;
        in_if.end_of_line  <= s.eol;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        encode_cell(s);
        if (s.n_typed == PRED) begin
          foreach (cell_codes[k]) pending_codes.push_back(cell_codes[k]);
        end else begin
          for (int k = 0; k < s.n_typed; k++)
            pending_codes.push_back('{s.typed[k], k == s.n_typed - 1});
        end
        accepted++;
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid <= 1'b0;

    while (pending_codes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cpre_pkg.sv
rtl/cpre_if.sv
rtl/cpre_front.sv
rtl/cpre_queue.sv
rtl/cpre_back.sv
rtl/cell_pixel_rle_encoder.sv
verif/testbench.sv
